// File: sv/sfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg: shared constants, types and CRC step for the sync frame receiver
// Frame layout, position codes, CRC-16/MCRF4XX byte update, result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sfrc_pkg;

  localparam int PAYLOAD_BYTES = 5;
  localparam int OUT_BYTES     = (PAYLOAD_BYTES < 5) ? PAYLOAD_BYTES : 5;
  localparam int BUTTON_W      = 40;

  localparam int POS_CRC_LOW_I  = 2 + PAYLOAD_BYTES;
  localparam int POS_CRC_HIGH_I = 3 + PAYLOAD_BYTES;
  localparam int POS_W          = $clog2(POS_CRC_HIGH_I + 1);

  localparam logic [POS_W-1:0] POS_WAIT     = '0;
  localparam logic [POS_W-1:0] POS_CRC_LOW  = POS_W'(POS_CRC_LOW_I);
  localparam logic [POS_W-1:0] POS_CRC_HIGH = POS_W'(POS_CRC_HIGH_I);
  localparam logic [POS_W-1:0] POS_PAYLOAD0 = POS_W'(2);

  localparam logic [7:0]  SYNC_RESET = 8'hA5;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  // result of one step of the framer
  typedef struct packed {
    logic                hit;      // this byte closes a frame
    logic                status;   // 1 = CRC mismatch
    logic [BUTTON_W-1:0] buttons;
    logic                waiting;  // hunting for sync
  } fr_res_t;

  // reflected 0x1021 (0x8408), one byte per call
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

// File: sv/sfrc_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_framer: frame position counter, running CRC and button store
// Consumes one byte per enabled cycle and flags the byte that ends a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrc_framer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [7:0]           sync_value,
  output sfrc_pkg::fr_res_t         res
);

  logic [sfrc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 crc_lo_r;
  logic [7:0]                 payload_r [sfrc_pkg::PAYLOAD_BYTES];
  logic [7:0]                 button_r  [sfrc_pkg::PAYLOAD_BYTES];
  logic                       crc_ok;
  logic                       final_byte;
  logic [sfrc_pkg::BUTTON_W-1:0] pack;

  assign final_byte = (pos_r != sfrc_pkg::POS_WAIT) && (pos_r > sfrc_pkg::POS_CRC_LOW);
  assign crc_ok     = (crc_r[7:0] == crc_lo_r) && (crc_r[15:8] == rx_byte);

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (pos_r == sfrc_pkg::POS_WAIT) begin
      if (rx_byte == sync_value) begin
        pos_nxt = sfrc_pkg::POS_W'(1);
        crc_nxt = sfrc_pkg::crc_add_byte(sfrc_pkg::CRC_INIT, rx_byte);
      end
    end else if (pos_r < sfrc_pkg::POS_CRC_LOW) begin
      pos_nxt = pos_r + sfrc_pkg::POS_W'(1);
      crc_nxt = sfrc_pkg::crc_add_byte(crc_r, rx_byte);
    end else if (pos_r == sfrc_pkg::POS_CRC_LOW) begin
      pos_nxt = pos_r + sfrc_pkg::POS_W'(1);
    end else begin
      pos_nxt = sfrc_pkg::POS_WAIT;
      crc_nxt = sfrc_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= sfrc_pkg::POS_WAIT;
      crc_r <= sfrc_pkg::CRC_INIT;
    end else if (step_en) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // payload capture and CRC low byte; no reset, always written before read
  always_ff @(posedge clk) begin
    if (step_en) begin
      if (pos_r == sfrc_pkg::POS_CRC_LOW) begin
        crc_lo_r <= rx_byte;
      end
      for (int k = 0; k < sfrc_pkg::PAYLOAD_BYTES; k++) begin
        if (pos_r == sfrc_pkg::POS_PAYLOAD0 + sfrc_pkg::POS_W'(k)) begin
          payload_r[k] <= rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sfrc_pkg::PAYLOAD_BYTES; k++) begin
        button_r[k] <= '0;
      end
    end else if (step_en && final_byte && crc_ok) begin
      for (int k = 0; k < sfrc_pkg::PAYLOAD_BYTES; k++) begin
        button_r[k] <= payload_r[k];
      end
    end
  end

  // store as it stands after this frame
  always_comb begin
    pack = '0;
    for (int k = 0; k < sfrc_pkg::OUT_BYTES; k++) begin
      pack[8*k +: 8] = crc_ok ? payload_r[k] : button_r[k];
    end
  end

  assign res.hit     = final_byte;
  assign res.status  = ~crc_ok;
  assign res.buttons = pack;
  assign res.waiting = (pos_r == sfrc_pkg::POS_WAIT);

endmodule

`default_nettype wire

// File: sv/sync_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16: sync-hunting frame receiver with CRC-16 check
// Result: the final byte passes the input register, then its result is registered onto out_tvalid.
// Throughput: one byte per cycle; a frame-end byte waits only while the
//   output register holds an item not yet taken.
// Reset (rst_n low, synchronous): hunt for sync, CRC 0xFFFF, buttons zero,
//   sync_value 0xA5, both stream registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_receiver_crc16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: sync_value
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata   // [0] frame_status, [40:1] button_bits, [47:41] 0
);

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  sync_r;
  logic        out_v_r;
  logic        out_status_r;
  logic [sfrc_pkg::BUTTON_W-1:0] out_buttons_r;
  logic        out_free;
  logic        go;
  sfrc_pkg::fr_res_t fr_res;

  assign out_free  = !out_v_r || out_tready;
  assign go        = in_v_r && (!fr_res.hit || out_free);
  assign in_tready = !in_v_r || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sfrc_pkg::SYNC_RESET;
    end else if (cfg_valid) begin
      sync_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  sfrc_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (go),
    .rx_byte    (in_byte_r),
    .sync_value (sync_r),
    .res        (fr_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go && fr_res.hit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && fr_res.hit) begin
      out_status_r  <= fr_res.status;
      out_buttons_r <= fr_res.buttons;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'h00, out_buttons_r, out_status_r};

  // a frame-end byte is only consumed when the output register can take it
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && fr_res.hit) |-> out_free)
    else $error("frame result consumed while output register busy");

  // after the closing byte the framer hunts for sync again
  a_back_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (go && fr_res.hit) |=> fr_res.waiting)
    else $error("framer did not return to sync hunt after frame end");

  // a matched frame is reported as valid with frame_status 0
  a_ok_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (go && fr_res.hit && !fr_res.status) |=> (out_v_r && !out_status_r))
    else $error("accepted frame not reported as accepted");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_v_r && !in_v_r))
    else $error("stream registers not cleared by reset");

endmodule

`default_nettype wire
